### hdl/bmhpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared types and codes for the priority queue cell row.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

	localparam int VAL_W = 32;
	localparam int OUT_CNT_W = 9;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} op_t;

	// broadcast command to every cell
	typedef struct packed {
		logic                    ins;
		logic                    pop;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    valid;
		logic                    gt;
	} link_t;

endpackage
`default_nettype wire

### hdl/bmhpq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhpq_cell
// One slot of the sorted row: holds a value, shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
module bmhpq_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bmhpq_pkg::cmd_t  cmd,
	input  wire bmhpq_pkg::link_t left,
	input  wire bmhpq_pkg::link_t right,
	output bmhpq_pkg::link_t      link
);
	import bmhpq_pkg::*;

	logic signed [VAL_W-1:0] val_q;
	logic                    valid_q;
	logic                    gt;

	// new value belongs before this slot
	assign gt = !valid_q || (cmd.value > val_q);

	assign link.value = val_q;
	assign link.valid = valid_q;
	assign link.gt    = gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= right.valid;
		end else if (cmd.ins && gt) begin
			valid_q <= left.gt ? left.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			val_q <= right.value;
		end else if (cmd.ins && gt) begin
			val_q <= left.gt ? left.value : cmd.value;
		end
	end

endmodule
`default_nettype wire

### hdl/binary_max_heap_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Bounded max priority queue of signed 32-bit values on a row of sorted cells.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  operation, value
// out      out  out_valid/ out_stall popped_value, top_value, entry_count, error
//
// One item per cycle while in_stall is low: all cells update together in the accept
// cycle, and the result is registered and shows in the cycle after accept.
// A held result stalls the input only while out_stall is high.
// Reset clears the count, the cell valid bits and the result valid flag.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue #(
	parameter int CAPACITY = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               operation,
	input  wire logic signed [bmhpq_pkg::VAL_W-1:0] value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [bmhpq_pkg::VAL_W-1:0]      popped_value,
	output logic signed [bmhpq_pkg::VAL_W-1:0]      top_value,
	output logic [bmhpq_pkg::OUT_CNT_W-1:0]         entry_count,
	output logic                                    error
);
	import bmhpq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic signed [VAL_W-1:0] popped_q;
	logic signed [VAL_W-1:0] top_q;
	logic [CNT_W-1:0] cnt_out_q;
	logic             err_q;

	logic             fire;
	logic             is_pop;
	logic             full;
	logic             empty;
	logic             err;
	logic [CNT_W-1:0] count_nx;
	logic signed [VAL_W-1:0] popped_nx;
	logic signed [VAL_W-1:0] top_nx;
	logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;
	cmd_t             cmd;
	link_t            links [CAPACITY];
	link_t            head_link;
	link_t            tail_link;

	assign in_stall = out_valid_q && out_stall;
	assign fire     = in_valid && !in_stall;
	assign is_pop   = (op_t'(operation) == OP_POP);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign err      = is_pop ? empty : full;

	assign cmd.ins   = fire && !is_pop && !err;
	assign cmd.pop   = fire && is_pop && !err;
	assign cmd.value = value;

	assign head_link = '{value: '0, valid: 1'b1, gt: 1'b0};
	assign tail_link = '{value: '0, valid: 1'b0, gt: 1'b0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			bmhpq_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.cmd   (cmd),
				.left  (head_link),
				.right (links[i+1]),
				.link  (links[i])
			);
		end else if (i == CAPACITY - 1) begin : g_last
			bmhpq_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.cmd   (cmd),
				.left  (links[i-1]),
				.right (tail_link),
				.link  (links[i])
			);
		end else begin : g_mid
			bmhpq_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.cmd   (cmd),
				.left  (links[i-1]),
				.right (links[i+1]),
				.link  (links[i])
			);
		end
	end

	always_comb begin
		count_nx  = count_q;
		popped_nx = '0;
		top_nx    = links[0].valid ? links[0].value : '0;
		if (cmd.ins) begin
			count_nx = count_q + CNT_W'(1);
			top_nx   = (empty || (value > links[0].value)) ? value : links[0].value;
		end else if (cmd.pop) begin
			count_nx  = count_q - CNT_W'(1);
			popped_nx = links[0].value;
			top_nx    = links[1].valid ? links[1].value : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_nx;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			popped_q  <= popped_nx;
			top_q     <= top_nx;
			cnt_out_q <= count_nx;
			err_q     <= err;
		end
	end

	assign cnt_ext      = {{OUT_CNT_W{1'b0}}, cnt_out_q};
	assign out_valid    = out_valid_q;
	assign popped_value = popped_q;
	assign top_value    = top_q;
	assign entry_count  = cnt_ext[OUT_CNT_W-1:0];
	assign error        = err_q;

`ifndef SYNTHESIS
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		links[0].valid == (count_q != '0))
		else $error("head cell valid disagrees with count");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		links[0].valid && links[1].valid |-> links[0].value >= links[1].value)
		else $error("cell row out of order");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow count");

	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && err |=> count_q == $past(count_q))
		else $error("rejected item changed count");

	a_err_popped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && err_q |-> popped_q == '0)
		else $error("error result carries a popped value");
`endif

endmodule
`default_nettype wire

### test/heap_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heap_checker
// Watches both channels of the priority queue, predicts every result from its
// own max-heap copy and compares the results field by field, oldest first.
// ----------------------------------------------------------------------------
module heap_checker #(
	parameter int CAPACITY = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               in_stall,
	input  wire logic                               operation,
	input  wire logic signed [bmhpq_pkg::VAL_W-1:0] value,
	input  wire logic                               out_valid,
	input  wire logic                               out_stall,
	input  wire logic signed [bmhpq_pkg::VAL_W-1:0] popped_value,
	input  wire logic signed [bmhpq_pkg::VAL_W-1:0] top_value,
	input  wire logic [bmhpq_pkg::OUT_CNT_W-1:0]    entry_count,
	input  wire logic                               error,
	output int                                      fail_count,
	output int                                      pending,
	output int                                      results_checked,
	output int                                      error_results,
	output int                                      peak_fill
);
	import bmhpq_pkg::*;

	typedef struct packed {
		logic signed [VAL_W-1:0] popped;
		logic signed [VAL_W-1:0] top;
		logic [OUT_CNT_W-1:0]    count;
		logic                    err;
	} heap_result_t;

	logic signed [VAL_W-1:0] heap_mem [0:CAPACITY-1];
	int                      fill;
	heap_result_t            heap_results_q [$];

	function automatic heap_result_t heap_step(input op_t op,
		input logic signed [VAL_W-1:0] v);
		heap_result_t            r;
		int                      pos;
		int                      up;
		int                      best;
		logic signed [VAL_W-1:0] tmp;
		r = '0;
		if (op == OP_INSERT) begin
			if (fill >= CAPACITY) begin
				r.err = 1'b1;
			end else begin
				heap_mem[fill] = v;
				pos = fill;
				fill++;
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (heap_mem[pos] <= heap_mem[up])
						break;
					tmp = heap_mem[pos];
					heap_mem[pos] = heap_mem[up];
					heap_mem[up] = tmp;
					pos = up;
				end
			end
		end else if (fill == 0) begin
			r.err = 1'b1;
		end else begin
			r.popped = heap_mem[0];
			fill--;
			heap_mem[0] = heap_mem[fill];
			pos = 0;
			while (1'b1) begin
				best = pos;
				// left child first; right wins only when strictly larger
				if (2 * pos + 1 < fill && heap_mem[2 * pos + 1] > heap_mem[best])
					best = 2 * pos + 1;
				if (2 * pos + 2 < fill && heap_mem[2 * pos + 2] > heap_mem[best])
					best = 2 * pos + 2;
				if (best == pos)
					break;
				tmp = heap_mem[pos];
				heap_mem[pos] = heap_mem[best];
				heap_mem[best] = tmp;
				pos = best;
			end
		end
		r.top = (fill > 0) ? heap_mem[0] : '0;
		r.count = fill[OUT_CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		heap_result_t want;
		if (!arst_n) begin
			fill = 0;
			heap_results_q.delete();
			fail_count = 0;
			pending = 0;
			results_checked = 0;
			error_results = 0;
			peak_fill = 0;
		end else begin
			if (in_valid && !in_stall) begin
				heap_results_q = {heap_results_q, heap_step(op_t'(operation), value)};
				if (fill > peak_fill)
					peak_fill = fill;
			end
			if (out_valid && !out_stall) begin
				if (heap_results_q.size() == 0) begin
					$error("result item with no expectation waiting");
					fail_count++;
				end else begin
					want = heap_results_q.pop_front();
					results_checked++;
					if (want.err)
						error_results++;
					if (popped_value !== want.popped) begin
						$error("popped_value: expected %0d, got %0d", want.popped,
							popped_value);
						fail_count++;
					end
					if (top_value !== want.top) begin
						$error("top_value: expected %0d, got %0d", want.top, top_value);
						fail_count++;
					end
					if (entry_count !== want.count) begin
						$error("entry_count: expected %0d, got %0d", want.count,
							entry_count);
						fail_count++;
					end
					if (error !== want.err) begin
						$error("error: expected %0b, got %0b", want.err, error);
						fail_count++;
					end
				end
			end
			pending = heap_results_q.size();
		end
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert and pop items into the priority queue: a short directed run,
// then a fill-to-full phase, a drain-to-empty phase and a mixed phase, under
// changing sender and receiver idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import bmhpq_pkg::*;

	localparam int CAPACITY = 256;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    operation = 1'b0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    out_stall = 1'b0;
	logic                    in_stall;
	logic                    out_valid;
	logic signed [VAL_W-1:0] popped_value;
	logic signed [VAL_W-1:0] top_value;
	logic [OUT_CNT_W-1:0]    entry_count;
	logic                    error;

	int fail_count;
	int pending;
	int results_checked;
	int error_results;
	int peak_fill;

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int cycle_cnt = 0;
	int items_sent = 0;

	binary_max_heap_priority_queue #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.popped_value(popped_value),
		.top_value(top_value),
		.entry_count(entry_count),
		.error(error)
	);

	heap_checker #(
		.CAPACITY(CAPACITY)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.popped_value(popped_value),
		.top_value(top_value),
		.entry_count(entry_count),
		.error(error),
		.fail_count(fail_count),
		.pending(pending),
		.results_checked(results_checked),
		.error_results(error_results),
		.peak_fill(peak_fill)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stalls, or one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	task automatic send_item(input op_t op, input logic signed [VAL_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		value <= v;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	// mostly full range, some extremes, some small values for equal keys
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $urandom_range(8) - 4;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(input int n, input int ins_pct, input int snd, input int rcv);
		snd_idle_pct = snd;
		rcv_idle_pct = rcv;
		repeat (n)
			send_item(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_POP, pick_value());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// pop on empty, extremes, equal keys, drain back to empty
		send_item(OP_POP, 32'sh12345678);
		send_item(OP_INSERT, 32'sh7fffffff);
		send_item(OP_INSERT, 32'sh80000000);
		send_item(OP_INSERT, 32'sh0);
		send_item(OP_INSERT, -32'sd1);
		send_item(OP_INSERT, 32'sd5);
		send_item(OP_INSERT, 32'sd5);
		send_item(OP_INSERT, 32'sd5);
		send_item(OP_INSERT, 32'sd1);
		send_item(OP_POP, 32'sh0);
		send_item(OP_POP, -32'sd1);
		send_item(OP_POP, 32'sh0);
		send_item(OP_INSERT, 32'sd5);
		send_item(OP_INSERT, 32'sh80000000);
		send_item(OP_INSERT, 32'sd5);
		send_item(OP_POP, 32'sh0);
		send_item(OP_POP, 32'sh0);
		send_item(OP_POP, 32'sh0);
		send_item(OP_POP, 32'sh0);
		send_item(OP_POP, 32'sh0);
		send_item(OP_POP, 32'sh0);
		send_item(OP_POP, 32'sh0);
		send_item(OP_POP, 32'sh0);

		run_phase(380, 95, 20, 76);
		run_phase(380, 10, 76, 20);
		hold_req = 1'b1;
		run_phase(390, 55, 0, 0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);

		$display("%0d items sent, %0d results checked, %0d error responses", items_sent,
			results_checked, error_results);
		$display("fill peaked at %0d of %0d entries", peak_fill, CAPACITY);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
